>>> src/fmqd_pkg.sv
// Package: shared widths, reset sample rate and CORDIC angle table.
package fmqd_pkg;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_ITER_DEF  = 16;
  localparam int PHASE_WIDTH_DEF  = 16;
  localparam int OUT_PHASE_W      = 16;
  localparam int RATE_W           = 27;
  localparam int FREQ_W           = 27;
  localparam int ACC_W            = 32;
  localparam int MAX_ITER         = 24;
  localparam logic [RATE_W-1:0] RATE_RESET = 27'd48000;

  function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] k);
    logic [ACC_W-1:0] r;
    case (k)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

>>> src/fmqd_if.sv
// Valid/ready stream interface.
interface fmqd_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fmqd_in_if #(parameter int SW = 16) (input logic clk);
  logic          valid;
  logic          ready;
  logic [SW-1:0] sample_i;
  logic [SW-1:0] sample_q;
  logic          block_start;
  modport source (output valid, output sample_i, output sample_q, output block_start,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input block_start,
                  output ready);
endinterface

interface fmqd_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [15:0] phase_step;
  logic [26:0] freq_hz;
  modport source (output valid, output phase_step, output freq_hz, input ready);
  modport sink   (input valid, input phase_step, input freq_hz, output ready);
endinterface

>>> src/fm_quadrature_demodulator.sv
// Top level: FM quadrature discriminator.
// The iterative CORDIC in the back end takes a new item only when idle and sets the pace;
//   the front end runs ahead by up to two items through the queue.
// Reset (rst, synchronous): clears history, queue and state; sample_rate returns to 48000.
module fm_quadrature_demodulator #(
  parameter int SAMPLE_WIDTH      = fmqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = fmqd_pkg::CORDIC_ITER_DEF,
  parameter int PHASE_WIDTH       = fmqd_pkg::PHASE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [fmqd_pkg::RATE_W-1:0] cfg_wdata,
  fmqd_in_if.sink    s_in,
  fmqd_out_if.source m_out
);
  import fmqd_pkg::*;
  localparam int PW = 2*SAMPLE_WIDTH + 1;

  // configuration register
  logic [RATE_W-1:0] sample_rate;
  always_ff @(posedge clk) begin
    if (rst) sample_rate <= RATE_RESET;
    else if (cfg_we) sample_rate <= cfg_wdata;
  end

  // front -> queue -> back, each transfer carries {re, im}
  fmqd_if #(.W(2*PW)) f2q (.clk(clk));
  fmqd_if #(.W(2*PW)) q2b (.clk(clk));

  fmqd_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .s_in(s_in), .q_out(f2q));

  fmqd_queue #(.W(2*PW)) u_queue (
    .clk(clk), .rst(rst), .q_in(f2q), .q_out(q2b));

  fmqd_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .PHASE_WIDTH(PHASE_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .sample_rate(sample_rate), .q_in(q2b), .m_out(m_out));
endmodule

>>> src/fmqd_front.sv
// Front end: history, conjugate product, first-sample filtering.
module fmqd_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  fmqd_in_if.sink s_in,
  fmqd_if.source  q_out
);
  import fmqd_pkg::*;
  localparam int PW = 2*SAMPLE_WIDTH + 1;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_SEND} fstate_t;
  fstate_t state;
  logic have_prev;
  logic signed [SAMPLE_WIDTH-1:0] prev_i, prev_q;
  logic signed [2*SAMPLE_WIDTH-1:0] p_ii, p_qq, p_iq, p_qi;
  logic signed [PW-1:0] re, im;

  assign s_in.ready  = (state == F_IDLE);
  assign q_out.valid = (state == F_SEND);
  assign q_out.data  = {re, im};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      have_prev <= 1'b0;
    end else begin
      case (state)
        F_IDLE: if (s_in.valid) begin
          prev_i <= s_in.sample_i;
          prev_q <= s_in.sample_q;
          have_prev <= 1'b1;
          p_ii <= $signed(prev_i) * $signed(s_in.sample_i);
          p_qq <= $signed(prev_q) * $signed(s_in.sample_q);
          p_iq <= $signed(prev_i) * $signed(s_in.sample_q);
          p_qi <= $signed(prev_q) * $signed(s_in.sample_i);
          if (!s_in.block_start && have_prev) state <= F_MUL;
        end
        F_MUL: begin
          re <= PW'(p_ii) + PW'(p_qq);
          im <= PW'(p_iq) - PW'(p_qi);
          state <= F_SEND;
        end
        F_SEND: if (q_out.ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

>>> src/fmqd_queue.sv
// Two-entry FIFO between front and back.
module fmqd_queue #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  fmqd_if.sink   q_in,
  fmqd_if.source q_out
);
  import fmqd_pkg::*;
  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign q_in.ready  = (cnt != 2'd2);
  assign q_out.valid = (cnt != 2'd0);
  assign q_out.data  = mem[rp];

  always_ff @(posedge clk) begin
    if (q_in.valid && q_in.ready) mem[wp] <= q_in.data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (q_in.valid && q_in.ready) wp <= ~wp;
      if (q_out.valid && q_out.ready) rp <= ~rp;
      cnt <= cnt + 2'(q_in.valid && q_in.ready) - 2'(q_out.valid && q_out.ready);
    end
  end
endmodule

>>> src/fmqd_back.sv
// Back end: iterative CORDIC atan2, rounding and frequency scaling.
module fmqd_back #(
  parameter int SAMPLE_WIDTH      = 16,
  parameter int CORDIC_ITERATIONS = 16,
  parameter int PHASE_WIDTH       = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [fmqd_pkg::RATE_W-1:0] sample_rate,
  fmqd_if.sink        q_in,
  fmqd_out_if.source  m_out
);
  import fmqd_pkg::*;
  localparam int PW = 2*SAMPLE_WIDTH + 1;
  localparam int XW = PW + 3;
  localparam int NI = (CORDIC_ITERATIONS < MAX_ITER) ? CORDIC_ITERATIONS : MAX_ITER;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (31 - PHASE_WIDTH);
  localparam logic [ACC_W-1:0] KEEP = ~((ACC_W'(1) << (32 - PHASE_WIDTH)) - ACC_W'(1));

  typedef enum logic [2:0] {B_IDLE, B_ITER, B_ROUND, B_MUL, B_OUT} bstate_t;
  bstate_t state;
  logic signed [XW-1:0] x, y;
  logic [ACC_W-1:0] z;
  logic [4:0] k;
  logic zero;
  logic signed [OUT_PHASE_W-1:0] ps;
  logic signed [OUT_PHASE_W+RATE_W:0] prod;
  logic signed [PW-1:0] re_in, im_in;
  logic [ACC_W-1:0] zr;

  assign re_in = q_in.data[2*PW-1:PW];
  assign im_in = q_in.data[PW-1:0];
  assign q_in.ready = (state == B_IDLE);
  assign m_out.valid = (state == B_OUT);
  assign m_out.phase_step = ps;
  assign m_out.freq_hz = prod[16 +: FREQ_W];
  assign zr = (z + HALF) & KEEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: if (q_in.valid) begin
          zero <= (re_in == '0) && (im_in == '0);
          k <= '0;
          if (re_in < 0) begin
            x <= -XW'(re_in); y <= -XW'(im_in); z <= 32'h80000000;
          end else begin
            x <= XW'(re_in); y <= XW'(im_in); z <= '0;
          end
          state <= B_ITER;
        end
        B_ITER: begin
          if (y > 0) begin
            x <= x + (y >>> k); y <= y - (x >>> k); z <= z + atan_turn(k);
          end else begin
            x <= x - (y >>> k); y <= y + (x >>> k); z <= z - atan_turn(k);
          end
          k <= k + 5'd1;
          if (k == 5'(NI-1)) state <= B_ROUND;
        end
        B_ROUND: begin
          ps <= zero ? '0 : $signed(zr[31:16]);
          state <= B_MUL;
        end
        B_MUL: begin
          prod <= ps * $signed({1'b0, sample_rate});
          state <= B_OUT;
        end
        B_OUT: if (m_out.ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

>>> src/fmqd_checker.sv
// Port-level checker for the demodulator, bound to the top level.
module fmqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] phase_step,
  input logic [26:0] freq_hz
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase_step))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_step == 16'd0 |-> freq_hz == 27'd0)
    else $error("zero phase with nonzero frequency");
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_step[15] |-> freq_hz[26] || freq_hz == 27'd0)
    else $error("frequency sign mismatch");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind fm_quadrature_demodulator fmqd_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(m_out.valid), .out_ready(m_out.ready),
  .phase_step(m_out.phase_step), .freq_hz(m_out.freq_hz));
